FILE: hdl/ufn_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ufn_pkg
// Shared types, code point constants and the mapping and encoding functions
// of the Arabic word-form normaliser.
// ----------------------------------------------------------------------------
package ufn_pkg;

   localparam int unsigned CP_W      = 21;
   localparam int unsigned MAX_ITEMS = 4;
   localparam int unsigned CNT_W     = 3;

   localparam logic [1:0] VER_TWO   = 2'd2;
   localparam logic [1:0] VER_RESET = 2'd3;

   localparam logic [CP_W-1:0] CP_QUESTION   = 21'h00003F;
   localparam logic [CP_W-1:0] CP_SPACE      = 21'h000020;
   localparam logic [CP_W-1:0] CP_SPACE_V2   = 21'h000001;
   localparam logic [CP_W-1:0] CP_NBSP       = 21'h0000A0;
   localparam logic [CP_W-1:0] CP_TATWEEL    = 21'h000640;
   localparam logic [CP_W-1:0] CP_HARAKA_LO  = 21'h00064B;
   localparam logic [CP_W-1:0] CP_HARAKA_HI  = 21'h000657;
   localparam logic [CP_W-1:0] CP_SUP_ALEF   = 21'h000670;
   localparam logic [CP_W-1:0] CP_ALEF_MADDA = 21'h000622;
   localparam logic [CP_W-1:0] CP_ALEF_HAMZA = 21'h000623;
   localparam logic [CP_W-1:0] CP_ALEF_BELOW = 21'h000625;
   localparam logic [CP_W-1:0] CP_ALEF_WASLA = 21'h000671;
   localparam logic [CP_W-1:0] CP_ALEF       = 21'h000627;
   localparam logic [CP_W-1:0] CP_WAW_HAMZA  = 21'h000624;
   localparam logic [CP_W-1:0] CP_WAW        = 21'h000648;
   localparam logic [CP_W-1:0] CP_YEH_HAMZA  = 21'h000626;
   localparam logic [CP_W-1:0] CP_FARSI_YEH  = 21'h0006CC;
   localparam logic [CP_W-1:0] CP_YEH        = 21'h00064A;
   localparam logic [CP_W-1:0] CP_KEHEH      = 21'h0006A9;
   localparam logic [CP_W-1:0] CP_SWASH_KAF  = 21'h0006AA;
   localparam logic [CP_W-1:0] CP_KAF        = 21'h000643;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_valid;
      logic       form_end;
   } rsp_type;

   // Results of one word, handed from the decoder to the output buffer
   typedef struct packed {
      logic [CNT_W-1:0]              cnt;
      rsp_type [MAX_ITEMS-1:0]       items;
   } batch_type;

   typedef struct packed {
      logic            drop;
      logic [CP_W-1:0] cp;
   } map_type;

   typedef struct packed {
      logic [CNT_W-1:0]      len;
      logic [3:0][7:0]       bytes;
   } enc_type;

   function automatic map_type map_code(input logic [CP_W-1:0] cp,
                                        input logic [1:0] ver);
      map_type m;
      m.drop = 1'b0;
      m.cp   = cp;
      if (cp inside {CP_TATWEEL, [CP_HARAKA_LO:CP_HARAKA_HI], CP_SUP_ALEF}) begin
         m.drop = 1'b1;
      end else if (cp inside {CP_ALEF_MADDA, CP_ALEF_HAMZA, CP_ALEF_BELOW,
                              CP_ALEF_WASLA}) begin
         m.cp = CP_ALEF;
      end else if (cp == CP_WAW_HAMZA) begin
         m.cp = CP_WAW;
      end else if (cp inside {CP_YEH_HAMZA, CP_FARSI_YEH}) begin
         m.cp = CP_YEH;
      end else if (cp inside {CP_KEHEH, CP_SWASH_KAF}) begin
         m.cp = CP_KAF;
      end else if (cp == CP_SPACE) begin
         m.cp = (ver == VER_TWO) ? CP_SPACE_V2 : CP_NBSP;
      end
      return m;
   endfunction

   function automatic enc_type encode(input logic [CP_W-1:0] cp);
      enc_type e;
      e.bytes = '0;
      if (cp < 21'h80) begin
         e.len      = 3'd1;
         e.bytes[0] = cp[7:0];
      end else if (cp < 21'h800) begin
         e.len      = 3'd2;
         e.bytes[0] = {3'b110, cp[10:6]};
         e.bytes[1] = {2'b10, cp[5:0]};
      end else if (cp < 21'h10000) begin
         e.len      = 3'd3;
         e.bytes[0] = {4'b1110, cp[15:12]};
         e.bytes[1] = {2'b10, cp[11:6]};
         e.bytes[2] = {2'b10, cp[5:0]};
      end else begin
         e.len      = 3'd4;
         e.bytes[0] = {5'b11110, cp[20:18]};
         e.bytes[1] = {2'b10, cp[17:12]};
         e.bytes[2] = {2'b10, cp[11:6]};
         e.bytes[3] = {2'b10, cp[5:0]};
      end
      return e;
   endfunction

endpackage
`default_nettype wire

FILE: hdl/utf8_arabic_form_normalizer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// utf8_arabic_form_normalizer
// Normalises the UTF-8 bytes of Arabic word forms, one byte per word.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one input byte with its last-byte flag per word; the word
//   is taken when req_valid is high and req_stall low. rsp_* returns output
//   bytes (or a bare end marker) under the same valid/stall rule; form_end
//   flags the final word of each form.
//   csr_wr_en writes csr_wr_data into the format version register; write it
//   only while the block is empty. Versions 0 and 1 pass bytes through, versions
//   2 and 3 decode, drop harakat and tatweel, and fold letter variants.
// Timing:
//   An accepted byte waits in the input register, where decoding and
//   re-encoding happen in a single pass, then moves to the result register
//   that drives rsp_*. Sustained rate is one byte per cycle while rsp_stall
//   is low and each byte yields at most one result; a byte that yields more
//   (up to four) holds the result register until its one read port drains it.
// Reset:
//   Synchronous, active high. Clears the decoder, empties both registers and
//   sets the format version to 3.
// Stall:
//   While rsp_stall is high the current result holds; the input register
//   still takes one more byte, then req_stall rises until the result drains.
// ----------------------------------------------------------------------------
module utf8_arabic_form_normalizer (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire ufn_pkg::req_type req_payload,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output ufn_pkg::rsp_type      rsp_payload,
   input  wire logic             csr_wr_en,
   input  wire logic [1:0]       csr_wr_data
);

   logic               in_valid_ff, in_valid_in;
   ufn_pkg::req_type   in_word_ff;
   logic [1:0]         version_ff;
   logic               buf_free;
   logic               advance;
   logic               accept;
   ufn_pkg::batch_type batch;

   // Advance the held byte into the result register once the buffer frees up
   assign advance   = in_valid_ff && buf_free;
   assign req_stall = in_valid_ff && !buf_free;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (advance) in_valid_in = 1'b0;
      if (accept)  in_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_word_ff <= req_payload;
      end
      if (reset) begin
         in_valid_ff <= 1'b0;
         version_ff  <= ufn_pkg::VER_RESET;
      end else begin
         in_valid_ff <= in_valid_in;
         if (csr_wr_en) begin
            version_ff <= csr_wr_data;
         end
      end
   end

   ufn_decoder u_decoder (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .word_in (in_word_ff),
      .version (version_ff),
      .batch   (batch)
   );

   ufn_out_buf u_out_buf (
      .clock       (clock),
      .reset       (reset),
      .load        (advance),
      .batch       (batch),
      .free        (buf_free),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule
`default_nettype wire

FILE: hdl/ufn_decoder.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ufn_decoder
// UTF-8 decoder state and single-pass mapping of one byte into up to four
// result items.
// ----------------------------------------------------------------------------
module ufn_decoder (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              advance,
   input  wire ufn_pkg::req_type  word_in,
   input  wire logic [1:0]        version,
   output ufn_pkg::batch_type     batch
);

   typedef struct packed {
      logic                              seen;
      logic [ufn_pkg::CP_W-1:0]          first;
      logic [ufn_pkg::CNT_W-1:0]         cnt;
      logic [3:0][7:0]                   bytes;
   } work_type;

   logic [ufn_pkg::CP_W-1:0] acc_ff, acc_in;
   logic [1:0]               pend_ff, pend_in;
   logic [ufn_pkg::CP_W-1:0] first_ff, first_in;
   logic                     seen_ff, seen_in;
   logic                     emitted_ff, emitted_in;

   function automatic work_type append(input work_type w, input ufn_pkg::enc_type e);
      work_type r;
      logic [ufn_pkg::CNT_W-1:0] off;
      r = w;
      for (int i = 0; i < 4; i++) begin
         off = ufn_pkg::CNT_W'(i) - w.cnt;
         if (ufn_pkg::CNT_W'(i) >= w.cnt && off < e.len) begin
            r.bytes[i] = e.bytes[off[1:0]];
         end
      end
      r.cnt = w.cnt + e.len;
      return r;
   endfunction

   function automatic work_type handle(input work_type w,
                                       input logic [ufn_pkg::CP_W-1:0] cp,
                                       input logic [1:0] ver);
      work_type r;
      ufn_pkg::map_type m;
      r = w;
      if (!r.seen) begin
         r.seen  = 1'b1;
         r.first = cp;
      end
      m = ufn_pkg::map_code(cp, ver);
      if (!m.drop) begin
         r = append(r, ufn_pkg::encode(m.cp));
      end
      return r;
   endfunction

   always_comb begin
      work_type w;
      logic [7:0] b;
      logic has1, has2, has3, start;
      logic [ufn_pkg::CP_W-1:0] c2;

      b       = word_in.in_byte;
      acc_in  = acc_ff;
      pend_in = pend_ff;
      w.seen  = seen_ff;
      w.first = first_ff;
      w.cnt   = '0;
      w.bytes = '0;
      has1    = 1'b0;
      has2    = 1'b0;
      has3    = 1'b0;
      start   = 1'b1;
      c2      = ufn_pkg::CP_QUESTION;

      if (!version[1]) begin
         // version one and zero: pass the byte straight through
         w.cnt      = 3'd1;
         w.bytes[0] = b;
      end else begin
         if (pend_in != 2'd0) begin
            if (b[7:6] == 2'b10) begin
               acc_in  = {acc_in[ufn_pkg::CP_W-7:0], b[5:0]};
               pend_in = pend_in - 2'd1;
               start   = 1'b0;
               if (pend_in == 2'd0) begin
                  has2 = 1'b1;
                  c2   = acc_in;
               end
            end else begin
               pend_in = 2'd0;
               has1    = 1'b1;
            end
         end
         if (start) begin
            if (b < 8'h80) begin
               has2 = 1'b1;
               c2   = {13'd0, b};
            end else if (b < 8'hC0 || b >= 8'hF8) begin
               has2 = 1'b1;
               c2   = ufn_pkg::CP_QUESTION;
            end else if (b < 8'hE0) begin
               acc_in  = {16'd0, b[4:0]};
               pend_in = 2'd1;
            end else if (b < 8'hF0) begin
               acc_in  = {17'd0, b[3:0]};
               pend_in = 2'd2;
            end else begin
               acc_in  = {18'd0, b[2:0]};
               pend_in = 2'd3;
            end
         end
         if (word_in.last_byte && pend_in != 2'd0) begin
            pend_in = 2'd0;
            has3    = 1'b1;
         end
         if (has1) w = handle(w, ufn_pkg::CP_QUESTION, version);
         if (has2) w = handle(w, c2, version);
         if (has3) w = handle(w, ufn_pkg::CP_QUESTION, version);
         // everything dropped: fall back to the first original code point
         if (word_in.last_byte && !emitted_ff && w.cnt == 3'd0 && w.seen) begin
            w = append(w, ufn_pkg::encode(w.first));
         end
      end

      for (int i = 0; i < ufn_pkg::MAX_ITEMS; i++) begin
         batch.items[i].out_byte   = w.bytes[i];
         batch.items[i].byte_valid = 1'b1;
         batch.items[i].form_end   = word_in.last_byte &&
                                     (w.cnt == ufn_pkg::CNT_W'(i + 1));
      end
      batch.cnt = w.cnt;
      if (word_in.last_byte && w.cnt == 3'd0) begin
         batch.items[0] = '{out_byte: 8'h00, byte_valid: 1'b0, form_end: 1'b1};
         batch.cnt      = 3'd1;
      end

      first_in   = w.first;
      seen_in    = w.seen;
      emitted_in = emitted_ff || (w.cnt != 3'd0);
      if (word_in.last_byte) begin
         acc_in     = '0;
         pend_in    = 2'd0;
         first_in   = '0;
         seen_in    = 1'b0;
         emitted_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff     <= '0;
         pend_ff    <= 2'd0;
         first_ff   <= '0;
         seen_ff    <= 1'b0;
         emitted_ff <= 1'b0;
      end else if (advance) begin
         acc_ff     <= acc_in;
         pend_ff    <= pend_in;
         first_ff   <= first_in;
         seen_ff    <= seen_in;
         emitted_ff <= emitted_in;
      end
   end

endmodule
`default_nettype wire

FILE: hdl/ufn_out_buf.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ufn_out_buf
// Result register holding up to four items of one word, drained one a cycle while rsp_stall is low.
// ----------------------------------------------------------------------------
module ufn_out_buf (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                load,
   input  wire ufn_pkg::batch_type  batch,
   output logic                     free,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output ufn_pkg::rsp_type         rsp_payload
);

   ufn_pkg::rsp_type [ufn_pkg::MAX_ITEMS-1:0] items_ff, items_in;
   logic [ufn_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   logic [1:0]                idx_ff, idx_in;
   logic                      take;

   assign rsp_valid   = (cnt_ff != 3'd0);
   assign rsp_payload = items_ff[idx_ff];
   assign take        = rsp_valid && !rsp_stall;
   assign free        = (cnt_ff == 3'd0) || (take && cnt_ff == 3'd1);

   always_comb begin
      items_in = items_ff;
      cnt_in   = cnt_ff;
      idx_in   = idx_ff;
      if (take) begin
         cnt_in = cnt_ff - 3'd1;
         idx_in = idx_ff + 2'd1;
      end
      if (load) begin
         items_in = batch.items;
         cnt_in   = batch.cnt;
         idx_in   = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      items_ff <= items_in;
      idx_ff   <= idx_in;
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

endmodule
`default_nettype wire
